@@ rtl/core/dpq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Shared constants, operation codes, beat types and the cell link types.
// ----------------------------------------------------------------------------
package dpq_pkg;

    localparam int CAPACITY = 64;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DROP_MAX = 2'd1,
        KIND_DROP_MIN = 2'd2,
        KIND_CLEAR    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] largest;
        logic signed [31:0] smallest;
        logic               is_empty;
        logic [1:0]         status;
    } out_beat_t;

    typedef struct packed {
        logic               en;
        kind_t              kind;
        logic signed [31:0] key;
    } cell_cmd_t;

    typedef struct packed {
        logic               occ;
        logic               gt;
        logic signed [31:0] val;
    } cell_link_t;

endpackage

@@ rtl/core/double_ended_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Bounded sorted multiset of signed values held in a chain of cells.
//
//   Channel   Ports                      Direction  Content
//   input     s_valid s_ready s_data     in         kind, value
//   result    m_valid m_ready m_data     out        largest, smallest,
//                                                   is_empty, status
//
// An accepted beat with status done updates every chain cell at that edge.
// The result beat is formed from the chain in the following cycle and held
// in an output register, and a new beat can be taken every cycle while
// results drain.
// A stalled result register holds the next beat in the pending stage.
// Reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module double_ended_priority_queue
    import dpq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    cell_link_t cell_out [CAPACITY];
    cell_cmd_t  cmd;

    logic      s_fire;
    logic      out_load;
    logic      full;
    logic      empty;
    status_t   status_new;
    logic      pend_reg;
    logic      pend_next;
    status_t   status_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_beat_t m_data_reg;
    out_beat_t result;

    localparam cell_link_t LEFT_EDGE  = '{occ: 1'b1, gt: 1'b0, val: '0};
    localparam cell_link_t RIGHT_EDGE = '{occ: 1'b0, gt: 1'b0, val: '0};

    assign full  = cell_out[CAPACITY-1].occ;
    assign empty = !cell_out[0].occ;

    always_comb begin
        status_new = STATUS_DONE;
        unique case (kind_t'(s_data.kind))
            KIND_INSERT:   if (full)  status_new = STATUS_FULL;
            KIND_DROP_MAX: if (empty) status_new = STATUS_EMPTY;
            KIND_DROP_MIN: if (empty) status_new = STATUS_EMPTY;
            KIND_CLEAR:    status_new = STATUS_DONE;
        endcase
    end

    assign out_load = pend_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !pend_reg || out_load;
    assign s_fire   = s_valid && s_ready;

    assign cmd = '{en:   s_fire && (status_new == STATUS_DONE),
                   kind: kind_t'(s_data.kind),
                   key:  s_data.value};

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_link_t left_in;
        cell_link_t right_in;
        if (i == 0) begin : g_first
            assign left_in = LEFT_EDGE;
        end else begin : g_mid_l
            assign left_in = cell_out[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in = RIGHT_EDGE;
        end else begin : g_mid_r
            assign right_in = cell_out[i+1];
        end
        dpq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_link  (left_in),
            .right_link (right_in),
            .own_link   (cell_out[i])
        );
    end

    always_comb begin
        logic top;
        result          = '0;
        result.is_empty = empty;
        result.status   = status_reg;
        if (!empty) begin
            result.smallest = cell_out[0].val;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            top = cell_out[i].occ &&
                  ((i == CAPACITY - 1) ? 1'b1 : !cell_out[(i + 1) % CAPACITY].occ);
            if (top) begin
                result.largest = result.largest | cell_out[i].val;
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_fire) begin
            pend_next = 1'b1;
        end else if (out_load) begin
            pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status_new;
        end
        if (out_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/dpq_cell.sv @@
// ----------------------------------------------------------------------------
// Double-ended priority queue cell
// One slot of the sorted chain; shifts, takes the new key or empties itself.
// ----------------------------------------------------------------------------
module dpq_cell
    import dpq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_cmd_t  cmd,
    input  cell_link_t left_link,
    input  cell_link_t right_link,
    output cell_link_t own_link
);

    logic               occ_reg;
    logic               occ_next;
    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    logic               gt;

    assign gt = occ_reg && (val_reg > cmd.key);

    always_comb begin
        val_next = val_reg;
        occ_next = occ_reg;
        if (cmd.en) begin
            unique case (cmd.kind)
                KIND_INSERT: begin
                    if (left_link.gt) begin
                        val_next = left_link.val;
                    end else if (left_link.occ && (!occ_reg || gt)) begin
                        val_next = cmd.key;
                    end
                    occ_next = occ_reg | left_link.occ;
                end
                KIND_DROP_MAX: begin
                    occ_next = occ_reg & right_link.occ;
                end
                KIND_DROP_MIN: begin
                    val_next = right_link.val;
                    occ_next = right_link.occ;
                end
                KIND_CLEAR: begin
                    occ_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign own_link = '{occ: occ_reg, gt: gt, val: val_reg};

endmodule
